FILE: hw/rtl/bpt_pkg.sv
// Shared types and constants for the bearing pair triangulation block.
// No dependencies.
`default_nettype none
package bpt_pkg;

  localparam int POSITION_WIDTH = 24;
  localparam int FIELD_W        = 16;
  localparam int DIFF_W         = FIELD_W + 1;
  localparam int DIR_W          = FIELD_W + 2;
  localparam int MUL_W          = FIELD_W + 1;
  localparam int PROD_W         = 2 * DIR_W;
  localparam int DEN_W          = PROD_W + 1;
  localparam int MAG_W          = PROD_W;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_PARALLEL  = 2'd2,
    ST_CLIPPED   = 2'd3
  } bpt_status_t;

  typedef struct packed {
    logic not_ready;
    logic parallel;
  } bpt_flags_t;

  localparam int FLAGS_W = $bits(bpt_flags_t);

endpackage
`default_nettype wire

FILE: hw/rtl/bpt_if.sv
// Valid/ready channel interfaces for the triangulation input and result beats.
// Depends on bpt_pkg for default widths.
`default_nettype none
interface bpt_in_if #(
  parameter int PW = bpt_pkg::POSITION_WIDTH
) ();
  logic                              valid;
  logic                              ready;
  logic signed [PW-1:0]              anchor_a_x;
  logic signed [PW-1:0]              anchor_a_y;
  logic signed [PW-1:0]              anchor_b_x;
  logic signed [PW-1:0]              anchor_b_y;
  logic signed [bpt_pkg::FIELD_W-1:0] field_a_x;
  logic signed [bpt_pkg::FIELD_W-1:0] field_a_y;
  logic signed [bpt_pkg::FIELD_W-1:0] field_b_x;
  logic signed [bpt_pkg::FIELD_W-1:0] field_b_y;
  logic signed [bpt_pkg::FIELD_W-1:0] rest_a_x;
  logic signed [bpt_pkg::FIELD_W-1:0] rest_a_y;
  logic signed [bpt_pkg::FIELD_W-1:0] rest_b_x;
  logic signed [bpt_pkg::FIELD_W-1:0] rest_b_y;

  modport source (
    output valid, anchor_a_x, anchor_a_y, anchor_b_x, anchor_b_y,
           field_a_x, field_a_y, field_b_x, field_b_y,
           rest_a_x, rest_a_y, rest_b_x, rest_b_y,
    input  ready
  );
  modport sink (
    input  valid, anchor_a_x, anchor_a_y, anchor_b_x, anchor_b_y,
           field_a_x, field_a_y, field_b_x, field_b_y,
           rest_a_x, rest_a_y, rest_b_x, rest_b_y,
    output ready
  );
endinterface

interface bpt_out_if #(
  parameter int PW = bpt_pkg::POSITION_WIDTH
) ();
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] point_x;
  logic signed [PW-1:0] point_y;
  logic [1:0]           status;

  modport source (output valid, point_x, point_y, status, input ready);
  modport sink (input valid, point_x, point_y, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bearing_pair_triangulation.sv
// Top level of the two-bearing triangulation block.
// Depends on bpt_pkg, bpt_if, bpt_front, bpt_queue, bpt_back.
//
// Accepts one anchor pair per clock unless back-pressure from out_ch stalls the
// pipeline, and returns one result per item in order. The path from input beat to
// result is three front stages, a two-entry queue, one divider stage per quotient
// bit (PW + 1, PW being the position width) and the result register. Two divider
// lanes run in parallel for x and y. anchors_ready is written through
// cfg_wr_en/cfg_wr_data and is sampled when an item enters.
`default_nettype none
module bearing_pair_triangulation #(
  parameter int POSITION_WIDTH = bpt_pkg::POSITION_WIDTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data,
  bpt_in_if.sink      in_ch,
  bpt_out_if.source   out_ch
);

  localparam int QW = 2 * (POSITION_WIDTH + 20 + bpt_pkg::MUL_W) + bpt_pkg::MAG_W + 2
                      + 2 * POSITION_WIDTH + bpt_pkg::FLAGS_W;

  logic          anchors_ready;
  logic          push, full, pop, empty;
  logic [QW-1:0] push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchors_ready <= 1'b0;
    end else if (cfg_wr_en) begin
      anchors_ready <= cfg_wr_data;
    end
  end

  bpt_front #(.PW(POSITION_WIDTH), .QW(QW)) u_front (
    .clk           (clk),
    .rst           (rst),
    .anchors_ready (anchors_ready),
    .in_ch         (in_ch),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  bpt_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  bpt_back #(.PW(POSITION_WIDTH), .QW(QW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/bpt_front.sv
// Front end: field differences, bearing directions, cross products and the
// dividend products. Three register stages. Depends on bpt_pkg, bpt_in_if.
`default_nettype none
module bpt_front #(
  parameter int PW = bpt_pkg::POSITION_WIDTH,
  parameter int QW = 2 * (PW + 20 + bpt_pkg::MUL_W) + bpt_pkg::MAG_W + 2 + 2 * PW
                     + bpt_pkg::FLAGS_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          anchors_ready,
  bpt_in_if.sink             in_ch,
  output logic               push,
  output logic [QW-1:0]      push_data,
  input  wire logic          full
);

  localparam int AW     = PW + 1;
  localparam int NUM_W  = PW + 20;
  localparam int NP_W   = bpt_pkg::DIR_W + AW;
  localparam int NW     = NUM_W + bpt_pkg::MUL_W;
  localparam int DIFF_W = bpt_pkg::DIFF_W;
  localparam int DIR_W  = bpt_pkg::DIR_W;

  logic en;
  logic v1, v2, v3;

  // stage 1
  logic signed [DIFF_W-1:0] fax, fay, fbx, fby;
  logic signed [DIR_W-1:0]  s1x_c, s1y_c, s2x_c, s2y_c;
  logic signed [DIR_W-1:0]  s1x, s1y, s2x, s2y;
  logic signed [AW-1:0]     dx, dy;
  logic signed [PW-1:0]     ax1, ay1;
  logic                     nr1;

  // stage 2
  logic signed [bpt_pkg::PROD_W-1:0] pd1, pd2;
  logic signed [NP_W-1:0]            pn1, pn2;
  logic signed [bpt_pkg::DEN_W-1:0]  den;
  logic signed [NUM_W-1:0]           num;
  logic signed [DIR_W-1:0]           s1x2, s1y2;
  logic signed [PW-1:0]              ax2, ay2;
  logic                              nr2;

  // stage 3
  logic [NUM_W-1:0]              num_mag;
  logic [bpt_pkg::MUL_W-1:0]     mx_mag, my_mag;
  logic [bpt_pkg::DEN_W-1:0]     den_abs;
  logic [NW-1:0]                 nx, ny;
  logic [bpt_pkg::MAG_W-1:0]     ud;
  logic                          negx, negy;
  logic signed [PW-1:0]          ax3, ay3;
  bpt_pkg::bpt_flags_t           flags3;

  assign en          = !(v3 && full);
  assign in_ch.ready = en;
  assign push        = v3 && !full;
  assign push_data   = {nx, ny, ud, negx, negy, ax3, ay3, flags3};

  always_comb begin
    fax = DIFF_W'(in_ch.field_a_x) - DIFF_W'(in_ch.rest_a_x);
    fay = DIFF_W'(in_ch.field_a_y) - DIFF_W'(in_ch.rest_a_y);
    fbx = DIFF_W'(in_ch.field_b_x) - DIFF_W'(in_ch.rest_b_x);
    fby = DIFF_W'(in_ch.field_b_y) - DIFF_W'(in_ch.rest_b_y);
    if (fax == '0 && fay == '0) begin
      s1x_c = DIR_W'(1);
      s1y_c = '0;
    end else begin
      s1x_c = -DIR_W'(fay);
      s1y_c = DIR_W'(fax);
    end
    if (fbx == '0 && fby == '0) begin
      s2x_c = DIR_W'(1);
      s2y_c = '0;
    end else begin
      s2x_c = -DIR_W'(fby);
      s2y_c = DIR_W'(fbx);
    end
  end

  always_comb begin
    pd1 = s1x * s2y;
    pd2 = s1y * s2x;
    pn1 = s2x * dy;
    pn2 = s2y * dx;
  end

  always_comb begin
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    mx_mag  = s1x2[DIR_W-1] ? bpt_pkg::MUL_W'(-s1x2) : bpt_pkg::MUL_W'(s1x2);
    my_mag  = s1y2[DIR_W-1] ? bpt_pkg::MUL_W'(-s1y2) : bpt_pkg::MUL_W'(s1y2);
    den_abs = den[bpt_pkg::DEN_W-1] ? bpt_pkg::DEN_W'(-den) : bpt_pkg::DEN_W'(den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1x  <= s1x_c;
      s1y  <= s1y_c;
      s2x  <= s2x_c;
      s2y  <= s2y_c;
      dx   <= AW'(in_ch.anchor_a_x) - AW'(in_ch.anchor_b_x);
      dy   <= AW'(in_ch.anchor_a_y) - AW'(in_ch.anchor_b_y);
      ax1  <= in_ch.anchor_a_x;
      ay1  <= in_ch.anchor_a_y;
      nr1  <= !anchors_ready;

      den  <= bpt_pkg::DEN_W'(pd1) - bpt_pkg::DEN_W'(pd2);
      num  <= NUM_W'(pn1) - NUM_W'(pn2);
      s1x2 <= s1x;
      s1y2 <= s1y;
      ax2  <= ax1;
      ay2  <= ay1;
      nr2  <= nr1;

      nx               <= NW'(num_mag) * NW'(mx_mag);
      ny               <= NW'(num_mag) * NW'(my_mag);
      ud               <= bpt_pkg::MAG_W'(den_abs);
      negx             <= num[NUM_W-1] ^ s1x2[DIR_W-1] ^ den[bpt_pkg::DEN_W-1];
      negy             <= num[NUM_W-1] ^ s1y2[DIR_W-1] ^ den[bpt_pkg::DEN_W-1];
      ax3              <= ax2;
      ay3              <= ay2;
      flags3.not_ready <= nr2;
      flags3.parallel  <= (den == '0);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bpt_queue.sv
// Two-entry queue between the front end and the divider back end.
// No dependencies.
`default_nettype none
module bpt_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bpt_div.sv
// Pipelined restoring divider lane, one quotient bit per stage, with
// overflow detect and a half-remainder flag for rounding. No dependencies.
`default_nettype none
module bpt_div #(
  parameter int NW = 61,
  parameter int DW = 36,
  parameter int QB = 25
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic [QB-1:0]      quo,
  output logic               rnd,
  output logic               ovf
);

  localparam int HW = NW - QB;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_r [1:QB];
  logic [DW-1:0] d_r   [1:QB];
  logic [QB-1:0] lo_r  [1:QB];
  logic [QB-1:0] q_r   [1:QB];
  logic          o_r   [1:QB];

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_stage
      logic [DW-1:0] rem_s, d_s;
      logic [QB-1:0] lo_s, q_s;
      logic          o_s, ge;
      logic [DW:0]   trial;
      if (k == 0) begin : g_first
        assign rem_s = DW'(num[NW-1:QB]);
        assign d_s   = den;
        assign lo_s  = num[QB-1:0];
        assign q_s   = '0;
        assign o_s   = CW'(num[NW-1:QB]) >= CW'(den);
      end else begin : g_next
        assign rem_s = rem_r[k];
        assign d_s   = d_r[k];
        assign lo_s  = lo_r[k];
        assign q_s   = q_r[k];
        assign o_s   = o_r[k];
      end
      assign trial = {rem_s, lo_s[QB-1]};
      assign ge    = trial >= {1'b0, d_s};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? DW'(trial - {1'b0, d_s}) : DW'(trial);
          d_r[k+1]   <= d_s;
          lo_r[k+1]  <= {lo_s[QB-2:0], 1'b0};
          q_r[k+1]   <= {q_s[QB-2:0], ge};
          o_r[k+1]   <= o_s;
        end
      end
    end
  endgenerate

  assign quo = q_r[QB];
  assign rnd = {rem_r[QB], 1'b0} >= {1'b0, d_r[QB]};
  assign ovf = o_r[QB];

endmodule
`default_nettype wire

FILE: hw/rtl/bpt_back.sv
// Back end: two divider lanes for the x and y offsets, then rounding,
// anchor add, saturation and the result register. Depends on bpt_pkg,
// bpt_div, bpt_out_if.
`default_nettype none
module bpt_back #(
  parameter int PW = bpt_pkg::POSITION_WIDTH,
  parameter int QW = 2 * (PW + 20 + bpt_pkg::MUL_W) + bpt_pkg::MAG_W + 2 + 2 * PW
                     + bpt_pkg::FLAGS_W
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [QW-1:0] pop_data,
  input  wire logic          empty,
  output logic               pop,
  bpt_out_if.source          out_ch
);

  localparam int NW  = PW + 20 + bpt_pkg::MUL_W;
  localparam int QB  = PW + 1;
  localparam int SW  = 2 + 2 * PW + bpt_pkg::FLAGS_W;
  localparam int SW2 = QB + 3;
  localparam logic signed [SW2-1:0] PMAX = {{(SW2-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic signed [SW2-1:0] PMIN = ~PMAX;

  logic                      en;
  logic [NW-1:0]             nx, ny;
  logic [bpt_pkg::MAG_W-1:0] ud;
  logic [SW-1:0]             side0;
  logic [SW-1:0]             side [1:QB];
  logic                      vld  [1:QB];
  logic [QB-1:0]             qx, qy;
  logic                      rx, ry, ox, oy;
  logic                      negx, negy;
  logic signed [PW-1:0]      ax, ay;
  bpt_pkg::bpt_flags_t       flags;
  logic [PW:0]               lane_x, lane_y;
  logic                      out_valid;
  logic signed [PW-1:0]      px, py;
  bpt_pkg::bpt_status_t      st;

  function automatic logic [PW:0] finish(input logic signed [PW-1:0] a,
                                         input logic [QB-1:0] q,
                                         input logic r, input logic o,
                                         input logic neg);
    logic [QB:0]           mag;
    logic signed [SW2-1:0] off, sum;
    logic                  hi, lo;
    mag = (QB+1)'(q) + (QB+1)'(r);
    off = neg ? -SW2'(mag) : SW2'(mag);
    sum = SW2'(a) + off;
    hi  = o ? !neg : (sum > PMAX);
    lo  = o ? neg : (sum < PMIN);
    if (hi) return {1'b1, PMAX[PW-1:0]};
    if (lo) return {1'b1, PMIN[PW-1:0]};
    return {1'b0, sum[PW-1:0]};
  endfunction

  assign en  = !out_valid || out_ch.ready;
  assign pop = !empty && en;
  assign {nx, ny, ud, side0} = pop_data;

  bpt_div #(.NW(NW), .DW(bpt_pkg::MAG_W), .QB(QB)) u_div_x (
    .clk (clk), .en (en), .num (nx), .den (ud), .quo (qx), .rnd (rx), .ovf (ox)
  );

  bpt_div #(.NW(NW), .DW(bpt_pkg::MAG_W), .QB(QB)) u_div_y (
    .clk (clk), .en (en), .num (ny), .den (ud), .quo (qy), .rnd (ry), .ovf (oy)
  );

  genvar k;
  generate
    for (k = 1; k <= QB; k++) begin : g_side
      if (k == 1) begin : g_head
        always_ff @(posedge clk) begin
          if (rst) begin
            vld[k] <= 1'b0;
          end else if (en) begin
            vld[k] <= pop;
          end
        end
        always_ff @(posedge clk) begin
          if (en) side[k] <= side0;
        end
      end else begin : g_tail
        always_ff @(posedge clk) begin
          if (rst) begin
            vld[k] <= 1'b0;
          end else if (en) begin
            vld[k] <= vld[k-1];
          end
        end
        always_ff @(posedge clk) begin
          if (en) side[k] <= side[k-1];
        end
      end
    end
  endgenerate

  assign {negx, negy, ax, ay, flags} = side[QB];

  always_comb begin
    lane_x = finish(ax, qx, rx, ox, negx);
    lane_y = finish(ay, qy, ry, oy, negy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flags.not_ready) begin
        px <= '0;
        py <= '0;
        st <= bpt_pkg::ST_NOT_READY;
      end else if (flags.parallel) begin
        px <= '0;
        py <= '0;
        st <= bpt_pkg::ST_PARALLEL;
      end else begin
        px <= lane_x[PW-1:0];
        py <= lane_y[PW-1:0];
        st <= (lane_x[PW] || lane_y[PW]) ? bpt_pkg::ST_CLIPPED : bpt_pkg::ST_FOUND;
      end
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.point_x = px;
  assign out_ch.point_y = py;
  assign out_ch.status  = st;

  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && (st == bpt_pkg::ST_NOT_READY || st == bpt_pkg::ST_PARALLEL)
      |-> px == '0 && py == '0)
    else $error("non-zero point with a failure status");

  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && st == bpt_pkg::ST_CLIPPED
      |-> px == PMAX[PW-1:0] || px == PMIN[PW-1:0]
       || py == PMAX[PW-1:0] || py == PMIN[PW-1:0])
    else $error("clipped status without a saturated coordinate");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(px) && $stable(py) && $stable(st) && vld[QB] == $past(vld[QB]))
    else $error("back end moved while stalled");

endmodule
`default_nettype wire

FILE: tb/sv/bearing_pair_triangulation_tb.sv
// Self-checking testbench for bearing_pair_triangulation: drives anchor pairs with random
// idling and stalls, predicts each crossing point and status, and checks every result beat.
// Depends on bpt_pkg, bpt_if and the bearing_pair_triangulation RTL.
module bearing_pair_triangulation_tb;

  localparam int PW = bpt_pkg::POSITION_WIDTH;
  localparam longint PMAX = (longint'(1) <<< (PW - 1)) - 1;
  localparam longint PMIN = -PMAX - 1;
  localparam logic [127:0] OFFSET_CAP = 128'd1 << 40;
  localparam int SETTLE = PW + 16;
  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [PW-1:0] ax, ay, bx, by;
    logic signed [15:0]   fax, fay, fbx, fby, rax, ray, rbx, rby;
  } pair_t;

  typedef struct {
    logic signed [PW-1:0]  px, py;
    bpt_pkg::bpt_status_t  st;
  } fix_t;

  logic clk, rst, cfg_wr_en, cfg_wr_data;
  bpt_in_if  #(.PW(PW)) in_ch ();
  bpt_out_if #(.PW(PW)) out_ch ();

  bearing_pair_triangulation #(.POSITION_WIDTH(PW)) dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  logic   anchors_placed;
  fix_t   pending_points[$];
  int     errors, sent, checked, hold_cycles, cycles;
  bit     steady;
  int     n_found, n_not_ready, n_parallel, n_clipped;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint offset(longint num, longint mul, longint den);
    logic neg;
    logic [127:0] prod, ud, q, rem;
    neg = ((num < 0) != (mul < 0)) != (den < 0);
    prod = 128'(mag(num)) * 128'(mag(mul));
    ud = 128'(mag(den));
    q = prod / ud;
    rem = prod % ud;
    if (rem >= ud - rem) q++;
    if (q > OFFSET_CAP) q = OFFSET_CAP;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clamp(longint v, ref logic clipped);
    if (v > PMAX) begin
      clipped = 1;
      return PMAX;
    end
    if (v < PMIN) begin
      clipped = 1;
      return PMIN;
    end
    return v;
  endfunction

  function automatic fix_t locate(pair_t p, logic placed);
    fix_t r;
    longint fx, fy, d1x, d1y, d2x, d2y, den, num, vx, vy;
    logic clipped;
    r.px = 0;
    r.py = 0;
    clipped = 0;
    if (!placed) begin
      r.st = bpt_pkg::ST_NOT_READY;
      return r;
    end
    fx = longint'(p.fax) - longint'(p.rax);
    fy = longint'(p.fay) - longint'(p.ray);
    d1x = (fx == 0 && fy == 0) ? 1 : -fy;
    d1y = (fx == 0 && fy == 0) ? 0 : fx;
    fx = longint'(p.fbx) - longint'(p.rbx);
    fy = longint'(p.fby) - longint'(p.rby);
    d2x = (fx == 0 && fy == 0) ? 1 : -fy;
    d2y = (fx == 0 && fy == 0) ? 0 : fx;
    den = d1x * d2y - d1y * d2x;
    if (den == 0) begin
      r.st = bpt_pkg::ST_PARALLEL;
      return r;
    end
    num = d2x * (longint'(p.ay) - longint'(p.by)) - d2y * (longint'(p.ax) - longint'(p.bx));
    vx = clamp(longint'(p.ax) + offset(num, d1x, den), clipped);
    vy = clamp(longint'(p.ay) + offset(num, d1y, den), clipped);
    r.px = vx[PW-1:0];
    r.py = vy[PW-1:0];
    r.st = clipped ? bpt_pkg::ST_CLIPPED : bpt_pkg::ST_FOUND;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("beat %0d: %s got %0h want %0h", checked, what, got, want);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    fix_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        report("unexpected beat status", 64'(out_ch.status), 64'd0);
      end else begin
        w = pending_points.pop_front();
        if (out_ch.point_x !== w.px)
          report("point_x", 64'(out_ch.point_x), 64'(w.px));
        if (out_ch.point_y !== w.py)
          report("point_y", 64'(out_ch.point_y), 64'(w.py));
        if (out_ch.status !== w.st)
          report("status", 64'(out_ch.status), 64'(w.st));
      end
      checked++;
    end
  end

  initial begin
    int stall;
    out_ch.ready = 0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 19);
      if (stall > 0 || hold_cycles > 0) out_ch.ready <= 0;
      repeat (stall) @(posedge clk);
      while (hold_cycles > 0) begin
        @(posedge clk);
        hold_cycles--;
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send(pair_t p);
    int gap;
    fix_t w;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.anchor_a_x <= p.ax;
    in_ch.anchor_a_y <= p.ay;
    in_ch.anchor_b_x <= p.bx;
    in_ch.anchor_b_y <= p.by;
    in_ch.field_a_x <= p.fax;
    in_ch.field_a_y <= p.fay;
    in_ch.field_b_x <= p.fbx;
    in_ch.field_b_y <= p.fby;
    in_ch.rest_a_x <= p.rax;
    in_ch.rest_a_y <= p.ray;
    in_ch.rest_b_x <= p.rbx;
    in_ch.rest_b_y <= p.rby;
    in_ch.valid <= 1;
    do @(posedge clk); while (!in_ch.ready);
    w = locate(p, anchors_placed);
    pending_points.push_back(w);
    case (w.st)
      bpt_pkg::ST_FOUND:     n_found++;
      bpt_pkg::ST_NOT_READY: n_not_ready++;
      bpt_pkg::ST_PARALLEL:  n_parallel++;
      default:               n_clipped++;
    endcase
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending_points.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_placed(logic v);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    anchors_placed = v;
  endtask

  function automatic pair_t make_pair(int kind);
    pair_t p;
    logic [31:0] r;
    logic signed [15:0] dx, dy;
    int sh;
    sh = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4, 12);
    r = $urandom; p.ax = $signed(r[PW-1:0]) >>> sh;
    r = $urandom; p.ay = $signed(r[PW-1:0]) >>> sh;
    r = $urandom; p.bx = $signed(r[PW-1:0]) >>> sh;
    r = $urandom; p.by = $signed(r[PW-1:0]) >>> sh;
    r = $urandom; p.fax = r[15:0]; p.fay = r[31:16];
    r = $urandom; p.fbx = r[15:0]; p.fby = r[31:16];
    r = $urandom; p.rax = r[15:0]; p.ray = r[31:16];
    r = $urandom; p.rbx = r[15:0]; p.rby = r[31:16];
    if (kind == 1) begin
      if ($urandom_range(0, 1)) begin
        p.fax = p.rax;
        p.fay = p.ray;
      end else begin
        p.fbx = p.rbx;
        p.fby = p.rby;
      end
    end else if (kind == 2) begin
      dx = $signed(16'($urandom)) >>> 2;
      dy = $signed(16'($urandom)) >>> 2;
      p.rax = p.rax >>> 2; p.ray = p.ray >>> 2;
      p.rbx = p.rbx >>> 2; p.rby = p.rby >>> 2;
      p.fax = p.rax + dx; p.fay = p.ray + dy;
      if ($urandom_range(0, 1)) begin
        p.fbx = p.rbx + dx; p.fby = p.rby + dy;
      end else begin
        p.fbx = p.rbx - dx; p.fby = p.rby - dy;
      end
    end
    return p;
  endfunction

  function automatic pair_t fixed_pair(longint ax, longint ay, longint bx, longint by,
                                       longint fax, longint fay, longint fbx, longint fby,
                                       longint rax, longint ray, longint rbx, longint rby);
    pair_t p;
    p.ax = PW'(ax); p.ay = PW'(ay); p.bx = PW'(bx); p.by = PW'(by);
    p.fax = 16'(fax); p.fay = 16'(fay); p.fbx = 16'(fbx); p.fby = 16'(fby);
    p.rax = 16'(rax); p.ray = 16'(ray); p.rbx = 16'(rbx); p.rby = 16'(rby);
    return p;
  endfunction

  task automatic test_not_ready();
    send(fixed_pair(PMAX, PMIN, PMIN, PMAX, 32767, -32768, 100, 5, 0, 0, 0, 0));
    send(make_pair(0));
    send(make_pair(0));
  endtask

  task automatic test_directed();
    set_placed(1);
    send(fixed_pair(0, 0, 65536, 0, 0, 100, 100, 0, 0, 0, 0, 0));
    send(fixed_pair(0, 0, 65536, 65536, 0, 0, 100, 100, 0, 0, 0, 0));
    send(fixed_pair(0, 0, 65536, 0, 5, 5, 0, 0, 5, 5, 7, 7));
    send(fixed_pair(0, 0, 65536, 0, 3, 4, 6, 8, 0, 0, 0, 0));
    send(fixed_pair(0, 0, 65536, 0, 3, 4, -3, -4, 0, 0, 0, 0));
    send(fixed_pair(0, 0, 0, 0, 10, 20, 20, 10, 0, 0, 0, 0));
    send(fixed_pair(PMAX, PMAX, PMIN, PMIN, 1, 0, 0, 1, 0, 0, 0, 0));
    send(fixed_pair(PMIN, PMAX, PMAX, PMIN, 1, 1, 1, 2, 0, 0, 0, 0));
    send(fixed_pair(PMAX, 0, PMIN, 65536, 1, 1000, 1, 999, 0, 0, 0, 0));
    send(fixed_pair(PMIN, PMIN, PMAX, PMAX, 32767, -32768, -32768, 32767,
                    -32768, 32767, 32767, -32768));
    send(fixed_pair(0, 0, 65536, 0, 32767, 32767, -32768, 32767,
                    -32768, -32768, 32767, -32768));
    send(fixed_pair(-1, -1, 1, 1, -1, 1, 1, 1, 0, 0, 0, 0));
    send(fixed_pair(0, 0, 3, 0, 2, 1, 1, 2, 0, 0, 0, 0));
    send(fixed_pair(0, 0, -3, 0, 2, 1, 1, 2, 0, 0, 0, 0));
    send(fixed_pair(100, 200, 300, 400, 1, -1, 1, 1, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      send(make_pair(k < 7 ? 0 : (k < 8 ? 1 : 2)));
    end
  endtask

  task automatic test_fill_stall();
    drain();
    hold_cycles = 300;
    steady = 1;
    test_random(80);
    steady = 0;
    drain();
  endtask

  task automatic test_steady_stretch();
    steady = 1;
    test_random(150);
    steady = 0;
  endtask

  task automatic test_toggle_ready();
    set_placed(0);
    test_random(40);
    set_placed(1);
    test_random(40);
  endtask

  initial begin
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    in_ch.valid = 0;
    in_ch.anchor_a_x = 0; in_ch.anchor_a_y = 0; in_ch.anchor_b_x = 0; in_ch.anchor_b_y = 0;
    in_ch.field_a_x = 0; in_ch.field_a_y = 0; in_ch.field_b_x = 0; in_ch.field_b_y = 0;
    in_ch.rest_a_x = 0; in_ch.rest_a_y = 0; in_ch.rest_b_x = 0; in_ch.rest_b_y = 0;
    anchors_placed = 0;
    errors = 0; sent = 0; checked = 0; hold_cycles = 0; cycles = 0; steady = 0;
    n_found = 0; n_not_ready = 0; n_parallel = 0; n_clipped = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_not_ready();
    test_directed();
    test_random(600);
    test_fill_stall();
    test_steady_stretch();
    test_toggle_ready();
    drain();
    $display("%0d pairs sent, %0d results checked, %0d mismatches", sent, checked, errors);
    $display("found %0d, not ready %0d, parallel %0d, clipped %0d",
             n_found, n_not_ready, n_parallel, n_clipped);
    if (errors == 0 && pending_points.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
